// ===== src/whp_pkg.sv =====
// shared types, codes and constants for the wav header parser
package whp_pkg;

	// default limit on the offset of the next chunk during the fmt search
	localparam int unsigned SEARCH_LIMIT_DEF = 1024;

	// chunk tags as seen in the little-endian shift word
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	// unsigned to signed sample bias
	localparam logic [7:0] SIGN_BIAS = 8'd128;

	// pcm format code, low byte
	localparam logic [7:0] FMT_PCM = 8'd1;

	// offset of the first chunk after the riff header
	localparam int unsigned FIRST_CHUNK = 12;

	// result kinds
	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// error codes
	localparam logic [2:0] ERR_NOT_RIFF  = 3'd0;
	localparam logic [2:0] ERR_NOT_WAVE  = 3'd1;
	localparam logic [2:0] ERR_NO_FMT    = 3'd2;
	localparam logic [2:0] ERR_NOT_PCM   = 3'd3;
	localparam logic [2:0] ERR_NO_DATA   = 3'd4;

	// parser phase
	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_HEAD    = 4'd1,
		PH_TAG     = 4'd2,
		PH_SIZE    = 4'd3,
		PH_SEEK    = 4'd4,
		PH_FMT     = 4'd5,
		PH_PAYLOAD = 4'd6,
		PH_DONE    = 4'd7
	} phase_t;

	// one input word
	typedef struct packed {
		logic [7:0] in_byte;
		logic       file_start;
	} in_word_t;

	// one result word
	typedef struct packed {
		logic [1:0]        kind;
		logic signed [7:0] sample;
		logic              last_sample;
		logic [2:0]        error_code;
		logic [31:0]       sample_rate;
		logic [7:0]        channel_count;
		logic [7:0]        bits_per_sample;
		logic [31:0]       payload_length;
	} out_word_t;

endpackage

// ===== src/whp_parser.sv =====
// parser state and the per-byte parse step
module whp_parser #(
	parameter int unsigned SEARCH_LIMIT = whp_pkg::SEARCH_LIMIT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  whp_pkg::in_word_t  word,
	output logic               hit,
	output whp_pkg::out_word_t result
);

	localparam int unsigned OFS_W = $clog2(SEARCH_LIMIT);
	localparam int unsigned POS_W = $clog2(SEARCH_LIMIT + 32);

	whp_pkg::phase_t phase_q, phase_d, ph0, ph1;
	logic [POS_W-1:0] pos_q, pos_d, pos0;
	logic [31:0]      shift_q, shift_d, shift0;
	logic [OFS_W-1:0] ofs_q, ofs_d, ofs0;
	logic [31:0]      rate_q, rate_d, rate0;
	logic [7:0]       chan_q, chan_d, chan0;
	logic [7:0]       bits_q, bits_d, bits0;
	logic [31:0]      rem_q, rem_d, rem0;
	logic [31:0]      rem_dec;
	logic [POS_W-1:0] ofs_ext;
	logic [POS_W-1:0] rel;
	logic [32:0]      nxt;
	logic [7:0]       b;

	// start flag clears the state seen by this byte
	always_comb begin
		b = word.in_byte;
		if (word.file_start) begin
			ph0    = whp_pkg::PH_HEAD;
			pos0   = '0;
			shift0 = '0;
			ofs0   = OFS_W'(whp_pkg::FIRST_CHUNK);
			rate0  = '0;
			chan0  = '0;
			bits0  = '0;
			rem0   = '0;
		end else begin
			ph0    = phase_q;
			pos0   = pos_q;
			shift0 = shift_q;
			ofs0   = ofs_q;
			rate0  = rate_q;
			chan0  = chan_q;
			bits0  = bits_q;
			rem0   = rem_q;
		end
	end

	// offset arithmetic
	always_comb begin
		ofs_ext = POS_W'(ofs0);
		rel     = pos0 - ofs_ext;
		rem_dec = rem0 - 32'd1;
		nxt     = 33'(ofs0) + {1'b0, shift_d} + 33'd8;
	end

	// seek reaching the next chunk start turns into a tag read
	always_comb begin
		ph1 = ph0;
		if ((ph0 == whp_pkg::PH_SEEK) && (pos0 == ofs_ext)) begin
			ph1 = whp_pkg::PH_TAG;
		end
	end

	// next state and result
	always_comb begin
		phase_d = ph0;
		pos_d   = pos0;
		shift_d = shift0;
		ofs_d   = ofs0;
		rate_d  = rate0;
		chan_d  = chan0;
		bits_d  = bits0;
		rem_d   = rem0;
		hit     = 1'b0;
		result  = '0;
		if ((ph0 == whp_pkg::PH_IDLE) || (ph0 == whp_pkg::PH_DONE)) begin
			hit = 1'b0;
		end else if (ph0 == whp_pkg::PH_PAYLOAD) begin
			// payload byte becomes a signed sample
			hit                = 1'b1;
			result.kind        = whp_pkg::KIND_SAMPLE;
			result.sample      = $signed(b - whp_pkg::SIGN_BIAS);
			result.last_sample = (rem0 == 32'd1);
			rem_d              = rem_dec;
			if (rem_dec == 32'd0) begin
				phase_d = whp_pkg::PH_DONE;
			end
		end else begin
			shift_d = {b, shift0[31:8]};
			pos_d   = pos0 + POS_W'(1);
			phase_d = ph1;
			case (ph1)
				whp_pkg::PH_HEAD: begin
					if ((pos0 == POS_W'(3)) && (shift_d != whp_pkg::TAG_RIFF)) begin
						hit               = 1'b1;
						result.kind       = whp_pkg::KIND_ERROR;
						result.error_code = whp_pkg::ERR_NOT_RIFF;
						phase_d           = whp_pkg::PH_DONE;
					end else if (pos0 == POS_W'(11)) begin
						if (shift_d != whp_pkg::TAG_WAVE) begin
							hit               = 1'b1;
							result.kind       = whp_pkg::KIND_ERROR;
							result.error_code = whp_pkg::ERR_NOT_WAVE;
							phase_d           = whp_pkg::PH_DONE;
						end else begin
							phase_d = whp_pkg::PH_TAG;
							ofs_d   = OFS_W'(whp_pkg::FIRST_CHUNK);
						end
					end
				end
				whp_pkg::PH_TAG: begin
					if (pos0 == ofs_ext + POS_W'(3)) begin
						phase_d = (shift_d == whp_pkg::TAG_FMT) ? whp_pkg::PH_FMT
							: whp_pkg::PH_SIZE;
					end
				end
				whp_pkg::PH_SIZE: begin
					// skip the chunk, or give up at or past the search limit
					if (pos0 == ofs_ext + POS_W'(7)) begin
						if (nxt >= 33'(SEARCH_LIMIT)) begin
							hit               = 1'b1;
							result.kind       = whp_pkg::KIND_ERROR;
							result.error_code = whp_pkg::ERR_NO_FMT;
							phase_d           = whp_pkg::PH_DONE;
						end else begin
							ofs_d   = nxt[OFS_W-1:0];
							phase_d = whp_pkg::PH_SEEK;
						end
					end
				end
				whp_pkg::PH_FMT: begin
					// fixed-offset fields of the fmt chunk and the data header
					if (rel == POS_W'(10)) begin
						chan_d = b;
					end
					if (rel == POS_W'(15)) begin
						rate_d = shift_d;
					end
					if (rel == POS_W'(22)) begin
						bits_d = b;
					end
					if ((rel == POS_W'(8)) && (b != whp_pkg::FMT_PCM)) begin
						hit               = 1'b1;
						result.kind       = whp_pkg::KIND_ERROR;
						result.error_code = whp_pkg::ERR_NOT_PCM;
						phase_d           = whp_pkg::PH_DONE;
					end else if ((rel == POS_W'(27)) && (shift_d != whp_pkg::TAG_DATA)) begin
						hit               = 1'b1;
						result.kind       = whp_pkg::KIND_ERROR;
						result.error_code = whp_pkg::ERR_NO_DATA;
						phase_d           = whp_pkg::PH_DONE;
					end else if (rel == POS_W'(31)) begin
						hit                    = 1'b1;
						result.kind            = whp_pkg::KIND_HEADER;
						result.sample_rate     = rate0;
						result.channel_count   = chan0;
						result.bits_per_sample = bits0;
						result.payload_length  = shift_d;
						rem_d                  = shift_d;
						phase_d = (shift_d == 32'd0) ? whp_pkg::PH_DONE
							: whp_pkg::PH_PAYLOAD;
					end
				end
				default: begin
					hit = 1'b0;
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= whp_pkg::PH_IDLE;
			pos_q   <= '0;
			ofs_q   <= OFS_W'(whp_pkg::FIRST_CHUNK);
			rem_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			ofs_q   <= ofs_d;
			rem_q   <= rem_d;
		end
	end

	// captured fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			rate_q  <= '0;
			chan_q  <= '0;
			bits_q  <= '0;
		end else if (step) begin
			shift_q <= shift_d;
			rate_q  <= rate_d;
			chan_q  <= chan_d;
			bits_q  <= bits_d;
		end
	end

endmodule

// ===== src/wav_header_parse_sign_convert_core.sv =====
// top level: input register, parser and result register
//
// Takes a little-endian WAV file one byte per word on the file channel (file_start marks
// byte 0 and restarts parsing) and gives one header or error word, then one signed sample
// word per payload byte with the last one marked. One byte is taken every clock cycle
// while results are drained; a byte's result word passes from the parse into the result
// register. The input register and the result register each hold one word, and the
// parse of a byte is a single compare, shift and counter update between them. Bytes
// after an error or after the payload produce nothing. SEARCH_LIMIT bounds the offset
// of the next chunk while searching for the fmt chunk.
module wav_header_parse_sign_convert_core #(
	parameter int unsigned SEARCH_LIMIT = whp_pkg::SEARCH_LIMIT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               file_valid,
	output logic               file_ready,
	input  whp_pkg::in_word_t  file_word,
	output logic               res_valid,
	input  logic               res_ready,
	output whp_pkg::out_word_t res_word
);

	logic               valid_s1;
	whp_pkg::in_word_t  word_s1;
	logic               valid_s2;
	whp_pkg::out_word_t word_s2;
	logic               advance;
	logic               hit;
	whp_pkg::out_word_t result;

	// the held byte is parsed when the result register can take its result
	assign advance    = valid_s1 && (!valid_s2 || res_ready);
	assign file_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (file_ready) begin
			valid_s1 <= file_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (file_ready && file_valid) begin
			word_s1 <= file_word;
		end
	end

	// parse step
	whp_parser #(
		.SEARCH_LIMIT(SEARCH_LIMIT)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.word   (word_s1),
		.hit    (hit),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= hit;
		end else if (res_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hit) begin
			word_s2 <= result;
		end
	end

	assign res_valid = valid_s2;
	assign res_word  = word_s2;

endmodule

// ===== bench/wav_header_parse_sign_convert_check.sv =====
// result predictor and checker for the wav header parser
module wav_header_parse_sign_convert_check #(
	parameter int unsigned SEARCH_LIMIT = whp_pkg::SEARCH_LIMIT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               file_valid,
	input  logic               file_ready,
	input  whp_pkg::in_word_t  file_word,
	input  logic               res_valid,
	input  logic               res_ready,
	input  whp_pkg::out_word_t res_word,
	output int unsigned        mismatch_count,
	output int unsigned        words_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned REPORT_LIMIT = 10;

	// parser state as the block should hold it
	whp_pkg::phase_t parse_phase;
	logic [31:0] byte_pos;
	logic [31:0] shift_word;
	logic [32:0] chunk_start;
	logic [31:0] rate_seen;
	logic [7:0]  chans_seen;
	logic [7:0]  bits_seen;
	logic [31:0] bytes_left;

	// result words predicted but not yet seen, oldest first
	whp_pkg::out_word_t due_words[$];
	whp_pkg::out_word_t want;

	function automatic void clear_parser();
		parse_phase = whp_pkg::PH_IDLE;
		byte_pos    = '0;
		shift_word  = '0;
		chunk_start = 33'(whp_pkg::FIRST_CHUNK);
		rate_seen   = '0;
		chans_seen  = '0;
		bits_seen   = '0;
		bytes_left  = '0;
	endfunction

	function automatic void raise_error(input logic [2:0] code);
		whp_pkg::out_word_t res;
		res            = '0;
		res.kind       = whp_pkg::KIND_ERROR;
		res.error_code = code;
		due_words.push_back(res);
		parse_phase    = whp_pkg::PH_DONE;
	endfunction

	// advance the parser by one accepted byte and queue the word it yields
	task automatic parse_byte(input whp_pkg::in_word_t w);
		logic [31:0] pos;
		logic [32:0] rel;
		logic [32:0] next_start;
		whp_pkg::out_word_t res;
		res = '0;
		if (w.file_start) begin
			clear_parser();
			parse_phase = whp_pkg::PH_HEAD;
		end else if (parse_phase == whp_pkg::PH_IDLE || parse_phase >= whp_pkg::PH_DONE) begin
			return;
		end

		// payload bytes become signed samples
		if (parse_phase == whp_pkg::PH_PAYLOAD) begin
			res.kind        = whp_pkg::KIND_SAMPLE;
			res.sample      = w.in_byte - whp_pkg::SIGN_BIAS;
			res.last_sample = (bytes_left == 32'd1);
			due_words.push_back(res);
			bytes_left--;
			if (bytes_left == '0)
				parse_phase = whp_pkg::PH_DONE;
			return;
		end

		shift_word = {w.in_byte, shift_word[31:8]};
		pos = byte_pos;
		if (byte_pos != 32'hffff_ffff)
			byte_pos++;

		// end of a skipped chunk: the next tag starts here
		if (parse_phase == whp_pkg::PH_SEEK && {1'b0, pos} == chunk_start)
			parse_phase = whp_pkg::PH_TAG;

		case (parse_phase)
			whp_pkg::PH_HEAD: begin
				if (pos == 32'd3 && shift_word != whp_pkg::TAG_RIFF) begin
					raise_error(whp_pkg::ERR_NOT_RIFF);
				end else if (pos == 32'd11) begin
					if (shift_word != whp_pkg::TAG_WAVE) begin
						raise_error(whp_pkg::ERR_NOT_WAVE);
					end else begin
						parse_phase = whp_pkg::PH_TAG;
						chunk_start = 33'(whp_pkg::FIRST_CHUNK);
					end
				end
			end
			whp_pkg::PH_TAG: begin
				if ({1'b0, pos} == chunk_start + 33'd3)
					parse_phase = (shift_word == whp_pkg::TAG_FMT) ? whp_pkg::PH_FMT
						: whp_pkg::PH_SIZE;
			end
			whp_pkg::PH_SIZE: begin
				// size field complete: jump over the chunk or give up
				if ({1'b0, pos} == chunk_start + 33'd7) begin
					next_start = chunk_start + {1'b0, shift_word} + 33'd8;
					if (next_start >= 33'(SEARCH_LIMIT)) begin
						raise_error(whp_pkg::ERR_NO_FMT);
					end else begin
						chunk_start = next_start;
						parse_phase = whp_pkg::PH_SEEK;
					end
				end
			end
			whp_pkg::PH_FMT: begin
				// fixed layout from the start of the fmt chunk
				rel = {1'b0, pos} - chunk_start;
				if (rel == 33'd8 && w.in_byte != whp_pkg::FMT_PCM) begin
					raise_error(whp_pkg::ERR_NOT_PCM);
				end else if (rel == 33'd27 && shift_word != whp_pkg::TAG_DATA) begin
					raise_error(whp_pkg::ERR_NO_DATA);
				end else begin
					if (rel == 33'd10)
						chans_seen = w.in_byte;
					if (rel == 33'd15)
						rate_seen = shift_word;
					if (rel == 33'd22)
						bits_seen = w.in_byte;
					if (rel == 33'd31) begin
						res.kind            = whp_pkg::KIND_HEADER;
						res.sample_rate     = rate_seen;
						res.channel_count   = chans_seen;
						res.bits_per_sample = bits_seen;
						res.payload_length  = shift_word;
						due_words.push_back(res);
						bytes_left  = shift_word;
						parse_phase = (shift_word == '0) ? whp_pkg::PH_DONE
							: whp_pkg::PH_PAYLOAD;
					end
				end
			end
			default: ;
		endcase
	endtask

	// follow both channels: predict on input words, compare on result words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			due_words.delete();
			mismatch_count = 0;
			words_pending  = 0;
		end else begin
			if (file_valid && file_ready)
				parse_byte(file_word);
			if (res_valid && res_ready) begin
				if (due_words.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("%0t: result word with nothing expected: %s",
							$time, $sformatf("kind=%0d smp=%0d err=%0d",
							res_word.kind, res_word.sample, res_word.error_code));
				end else begin
					want = due_words.pop_front();
					if (res_word.kind !== want.kind || res_word.sample !== want.sample ||
					    res_word.last_sample !== want.last_sample ||
					    res_word.error_code !== want.error_code ||
					    res_word.sample_rate !== want.sample_rate ||
					    res_word.channel_count !== want.channel_count ||
					    res_word.bits_per_sample !== want.bits_per_sample ||
					    res_word.payload_length !== want.payload_length) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT) begin
							$display("%0t: result word mismatch", $time);
							$display("  expected kind=%0d smp=%0d last=%0b err=%0d",
								want.kind, want.sample, want.last_sample,
								want.error_code);
							$display("           rate=%h ch=%0d bits=%0d len=%h",
								want.sample_rate, want.channel_count,
								want.bits_per_sample, want.payload_length);
							$display("  actual   kind=%0d smp=%0d last=%0b err=%0d",
								res_word.kind, res_word.sample, res_word.last_sample,
								res_word.error_code);
							$display("           rate=%h ch=%0d bits=%0d len=%h",
								res_word.sample_rate, res_word.channel_count,
								res_word.bits_per_sample, res_word.payload_length);
						end
					end
				end
			end
			words_pending = due_words.size();
		end
	end

endmodule

// ===== bench/wav_header_parse_sign_convert_core_test.sv =====
// stimulus, idling and final verdict for the wav header parser
module wav_header_parse_sign_convert_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SEARCH_LIMIT = whp_pkg::SEARCH_LIMIT_DEF;
	localparam int          RANDOM_BYTES = 90;
	localparam int          CALM_BYTES   = 45;
	localparam int          HOLD_CYCLES  = 60;
	localparam int          STALL_LIMIT  = 1000;
	localparam int          DRAIN_CYCLES = 10;
	localparam int          HEADER_BYTES = 44;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               file_valid = 1'b0;
	logic               file_ready;
	whp_pkg::in_word_t  file_word  = '0;
	logic               res_valid;
	logic               res_ready  = 1'b0;
	whp_pkg::out_word_t res_word;

	int unsigned mismatch_count;
	int unsigned words_pending;

	// idling switch and long hold-off requests, both owned by the stimulus
	logic gaps_on       = 1'b1;
	int   hold_requests = 0;
	int   holds_done    = 0;
	int   stall_cycles  = 0;

	// bytes of the file under construction
	logic [7:0] wav_bytes[$];

	always #2 clk = ~clk;

	wav_header_parse_sign_convert_core #(
		.SEARCH_LIMIT(SEARCH_LIMIT)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.file_valid (file_valid),
		.file_ready (file_ready),
		.file_word  (file_word),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_word   (res_word)
	);

	wav_header_parse_sign_convert_check #(
		.SEARCH_LIMIT(SEARCH_LIMIT)
	) checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.file_valid     (file_valid),
		.file_ready     (file_ready),
		.file_word      (file_word),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.res_word       (res_word),
		.mismatch_count (mismatch_count),
		.words_pending  (words_pending)
	);

	// little-endian 32-bit field
	function automatic void put32(input logic [31:0] value);
		for (int i = 0; i < 4; i++)
			wav_bytes.push_back(value[8*i +: 8]);
	endfunction

	function automatic void start_wav();
		wav_bytes.delete();
		put32(whp_pkg::TAG_RIFF);
		put32($urandom());
		put32(whp_pkg::TAG_WAVE);
	endfunction

	// chunk other than fmt, with fill bytes that may fall short of its size
	function automatic void add_junk(input logic [31:0] size, input int fill);
		logic [31:0] tag;
		do
			tag = $urandom();
		while (tag == whp_pkg::TAG_FMT);
		put32(tag);
		put32(size);
		repeat (fill) wav_bytes.push_back(8'($urandom()));
	endfunction

	function automatic void add_fmt(input logic [7:0] fmt_low, input logic [7:0] chans,
			input logic [31:0] rate, input logic [7:0] bits);
		put32(whp_pkg::TAG_FMT);
		put32(32'd16);
		put32({8'($urandom()), chans, 8'($urandom()), fmt_low});
		put32(rate);
		put32($urandom());
		put32({8'($urandom()), bits, 16'($urandom())});
	endfunction

	function automatic void add_data(input logic [31:0] tag, input logic [31:0] len,
			input int count);
		put32(tag);
		put32(len);
		repeat (count) wav_bytes.push_back(8'($urandom()));
	endfunction

	// one word on the file channel, sometimes with a random gap before it
	task automatic send_byte(input logic [7:0] value, input logic first);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			file_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		file_valid <= 1'b1;
		file_word  <= '{in_byte: value, file_start: first};
		do
			@(posedge clk);
		while (!file_ready);
	endtask

	// bytes from index from up to upto of the built file, start flag on byte zero
	task automatic send_wav_part(input int from, input int upto);
		for (int i = from; i < upto && i < wav_bytes.size(); i++)
			send_byte(wav_bytes[i], i == 0);
	endtask

	// first count bytes of the built file
	task automatic send_wav(input int count);
		send_wav_part(0, count);
	endtask

	task automatic send_stray(input int count);
		repeat (count) send_byte(8'($urandom()), 1'b0);
	endtask

	// result side: ready runs, stall bursts and the requested long hold-off
	initial begin
		@(posedge arst_n);
		forever begin
			if (holds_done != hold_requests) begin
				holds_done++;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (gaps_on && $urandom_range(0, 2) == 0) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				res_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// watchdog: ends the run after a long stretch with no word moving
	initial begin
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((file_valid && file_ready) || (res_valid && res_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	// stimulus and verdict
	initial begin
		logic [31:0] size;
		logic [31:0] len;
		int          count;
		int          idx;
		int          file_bytes_sent;
		file_bytes_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bytes before any file start are dropped
		send_stray(3);

		// wrong riff tag, decided on byte three
		start_wav();
		wav_bytes[1] ^= 8'h20;
		send_wav(6);

		// wrong wave tag
		start_wav();
		wav_bytes[11] ^= 8'h01;
		send_wav(14);

		// format other than pcm
		start_wav();
		add_fmt(8'h03, 8'd2, 32'd44100, 8'd16);
		add_data(whp_pkg::TAG_DATA, 32'd4, 4);
		send_wav(wav_bytes.size());

		// data tag missing at its fixed offset
		start_wav();
		add_fmt(whp_pkg::FMT_PCM, 8'd1, 32'd8000, 8'd8);
		add_data(whp_pkg::TAG_DATA ^ 32'h0100_0000, 32'd2, 2);
		send_wav(wav_bytes.size());

		// largest chunk size: search gives up on the size field
		start_wav();
		add_junk(32'hffff_ffff, 6);
		send_wav(wav_bytes.size());

		// next chunk exactly at the search limit
		start_wav();
		add_junk(SEARCH_LIMIT - 20, 4);
		send_wav(wav_bytes.size());

		// next chunk just below the limit, then a restart while seeking
		start_wav();
		add_junk(SEARCH_LIMIT - 21, 4);
		send_wav(wav_bytes.size());

		// empty chunk, all-zero header fields, zero payload, trailing bytes dropped
		start_wav();
		add_junk(32'd0, 0);
		add_fmt(whp_pkg::FMT_PCM, 8'd0, 32'd0, 8'd0);
		add_data(whp_pkg::TAG_DATA, 32'd0, 0);
		send_wav(wav_bytes.size());
		send_stray(4);

		// all-ones header fields, sample extremes, receiver held off during the samples
		start_wav();
		add_fmt(whp_pkg::FMT_PCM, 8'hff, 32'hffff_ffff, 8'hff);
		add_data(whp_pkg::TAG_DATA, 32'd40, 40);
		wav_bytes[wav_bytes.size() - 4] = 8'h00;
		wav_bytes[wav_bytes.size() - 3] = 8'h7f;
		wav_bytes[wav_bytes.size() - 2] = 8'h80;
		wav_bytes[wav_bytes.size() - 1] = 8'hff;
		send_wav(HEADER_BYTES);
		hold_requests++;
		send_wav_part(HEADER_BYTES, wav_bytes.size());
		send_stray(2);

		// single sample, marked last
		start_wav();
		add_junk(32'd3, 3);
		add_fmt(whp_pkg::FMT_PCM, 8'd1, 32'd22050, 8'd8);
		add_data(whp_pkg::TAG_DATA, 32'd1, 1);
		send_wav(wav_bytes.size());

		// largest payload length, cut off by a restart
		start_wav();
		add_fmt(whp_pkg::FMT_PCM, 8'd2, 32'd48000, 8'd16);
		add_data(whp_pkg::TAG_DATA, 32'hffff_ffff, 5);
		send_wav(wav_bytes.size());

		// restart in the middle of the fmt chunk
		start_wav();
		add_fmt(whp_pkg::FMT_PCM, 8'd2, 32'd96000, 8'd24);
		send_wav(20);

		// two skipped chunks before fmt
		start_wav();
		add_junk(32'd2, 2);
		add_junk(32'd5, 5);
		add_fmt(whp_pkg::FMT_PCM, 8'd6, 32'd11025, 8'd8);
		add_data(whp_pkg::TAG_DATA, 32'd6, 6);
		send_wav(wav_bytes.size());
		send_stray(2);

		// random files, mostly well formed, some damaged, cut short or noise
		while (file_bytes_sent < RANDOM_BYTES) begin
			if (file_bytes_sent >= RANDOM_BYTES - CALM_BYTES)
				gaps_on = 1'b0;
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 8))
					send_byte(8'($urandom()), $urandom_range(0, 3) == 0);
			end else begin
				start_wav();
				repeat ($urandom_range(0, 2)) begin
					size = ($urandom_range(0, 11) == 0) ? $urandom() : $urandom_range(0, 10);
					add_junk(size, (size > 32'd10) ? 4 : int'(size));
				end
				add_fmt(($urandom_range(0, 15) == 0) ? 8'($urandom()) : whp_pkg::FMT_PCM,
					8'($urandom()), $urandom(), 8'($urandom()));
				len = $urandom_range(0, 12);
				count = len;
				if ($urandom_range(0, 9) == 0) begin
					len = $urandom();
					count = $urandom_range(0, 12);
				end
				add_data(($urandom_range(0, 15) == 0) ? 32'($urandom()) : whp_pkg::TAG_DATA,
					len, count);
				if ($urandom_range(0, 4) == 0) begin
					idx = $urandom_range(0, wav_bytes.size() - 1);
					wav_bytes[idx] ^= 8'($urandom_range(1, 255));
				end
				count = wav_bytes.size();
				if ($urandom_range(0, 7) == 0)
					count = $urandom_range(1, count);
				send_wav(count);
				file_bytes_sent += count;
				if ($urandom_range(0, 2) == 0)
					send_stray($urandom_range(1, 3));
			end
		end
		file_valid <= 1'b0;

		// drain what is still expected, then let the pipeline settle
		@(posedge clk);
		while (words_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (mismatch_count == 0 && words_pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/whp_pkg.sv
src/whp_parser.sv
src/wav_header_parse_sign_convert_core.sv
bench/wav_header_parse_sign_convert_check.sv
bench/wav_header_parse_sign_convert_core_test.sv
